### hw/rtl/upi_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the arctangent table of the unicycle pose integrator
// no dependencies
package upi_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int POSITION_BITS_DEF = 32;

    localparam int CORDIC_ITERS = 16;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int XY_W         = 33;
    localparam int Z_W          = 34;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam int MUL_A_W = 17;
    localparam int MUL_P_W = MUL_A_W + XY_W;
    localparam int ACC_W   = 64;
    localparam int POS_SHIFT = 38;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_VEL_MAX    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_STEP_LIMIT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_VEL_MAX       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_STEP_LIMIT    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME          = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_X             = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_Y             = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_HEADING       = 4'd7;

    typedef struct packed {
        logic start;
    } cordic_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_sts_t;

    function automatic logic [31:0] atan_value(input logic [ITER_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            4'd0:    v = 32'h20000000;
            4'd1:    v = 32'h12E4051E;
            4'd2:    v = 32'h09FB385B;
            4'd3:    v = 32'h051111D4;
            4'd4:    v = 32'h028B0D43;
            4'd5:    v = 32'h0145D7E1;
            4'd6:    v = 32'h00A2F61E;
            4'd7:    v = 32'h00517C55;
            4'd8:    v = 32'h0028BE53;
            4'd9:    v = 32'h00145F2F;
            4'd10:   v = 32'h000A2F98;
            4'd11:   v = 32'h000517CC;
            4'd12:   v = 32'h00028BE6;
            4'd13:   v = 32'h000145F3;
            4'd14:   v = 32'h0000A2FA;
            default: v = 32'h0000517D;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/upi_channels.sv
`timescale 1ns / 1ps
// valid/ready channels of the unicycle pose integrator: step command, pose result, config write
// depends on upi_pkg
interface upi_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] desired_forward;
    logic signed [15:0] desired_turn;
    modport source (output valid, output desired_forward, output desired_turn, input ready);
    modport sink (input valid, input desired_forward, input desired_turn, output ready);
endinterface

interface upi_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic        [14:0] forward_speed;
    logic signed [15:0] turn_rate;
    logic signed [15:0] forward_change;
    logic signed [15:0] turn_change;
    modport source (output valid, output pos_x, output pos_y, output heading,
                    output forward_speed, output turn_rate, output forward_change,
                    output turn_change, input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading,
                  input forward_speed, input turn_rate, input forward_change,
                  input turn_change, output ready);
endinterface

interface upi_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [upi_pkg::CFG_IDX_W-1:0]     index;
    logic [upi_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/upi_cordic.sv
`timescale 1ns / 1ps
// iterative cordic rotator: cos and sin of a binary angle in q2.30, one iteration per cycle
// depends on upi_pkg
module upi_cordic #(
    parameter int ANGLE_BITS = upi_pkg::ANGLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  upi_pkg::cordic_ctl_t                 ctl,
    input  logic [ANGLE_BITS-1:0]                angle,
    output upi_pkg::cordic_sts_t                 sts,
    output logic signed [upi_pkg::XY_W-1:0]      cos_val,
    output logic signed [upi_pkg::XY_W-1:0]      sin_val
);

    localparam int XW = upi_pkg::XY_W;
    localparam int ZW = upi_pkg::Z_W;
    localparam logic [upi_pkg::ITER_W-1:0] LAST_ITER =
        upi_pkg::ITER_W'(upi_pkg::CORDIC_ITERS - 1);

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [upi_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic flip_reg, flip_next;
    logic busy_reg, busy_next, fix_reg, fix_next, done_reg, done_next;

    logic [31:0] a32, a_fix;
    logic flip_in;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] atan_s;

    assign a32     = 32'(angle) << (32 - ANGLE_BITS);
    assign flip_in = a32[31] ^ a32[30];
    assign a_fix   = {a32[31] ^ flip_in, a32[30:0]};
    assign xs      = x_reg >>> iter_reg;
    assign ys      = y_reg >>> iter_reg;
    assign atan_s  = $signed({2'b00, upi_pkg::atan_value(iter_reg)});

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        if (ctl.start)
        begin
            x_next    = upi_pkg::CORDIC_GAIN;
            y_next    = '0;
            z_next    = ZW'($signed(a_fix));
            iter_next = '0;
            flip_next = flip_in;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ZW-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_s;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_s;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == LAST_ITER)
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            x_next    = flip_reg ? -x_reg : x_reg;
            y_next    = flip_reg ? -y_reg : y_reg;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign sts.busy = busy_reg | fix_reg;
    assign sts.done = done_reg;
    assign cos_val  = x_reg;
    assign sin_val  = y_reg;

endmodule

### hw/rtl/unicycle_pose_integrator.sv
`timescale 1ns / 1ps
// unicycle pose integrator top level: config registers, velocity slew, sequencer, shared multiplier
// depends on upi_pkg, upi_channels, upi_cordic
//
// cmd carries one time step (desired forward speed and turn rate); pose returns one result
// per step: position, heading, velocities and the applied velocity changes.
// cfg writes one register per transfer (index 0..7, higher indexes ignored); cfg.ready is
// always high. writes to init_x, init_y, init_heading load the pose at once.
// a step runs from cmd transfer to pose.valid through slew and heading (S_TGT, S_CHG,
// S_HMUL, S_HADD), the cordic start, the wait on the cordic (16 iterations, a quadrant
// fix and the done flag), the position products on the one 17 x 33 multiplier and the
// load of the result.
// cmd.ready is high only while the sequencer is idle, so a new step is taken only after
// the last one has left S_DONE; the rate is set by the cordic iterations and multiplier passes.
// the result sits in an output register; a finished step waits there and the next
// command is taken meanwhile. if the receiver stalls, the following step holds in its
// last state until the output register is free.
// reset: pose, velocities zero, limits at their default values, no result pending.
module unicycle_pose_integrator #(
    parameter int ANGLE_BITS    = upi_pkg::ANGLE_BITS_DEF,
    parameter int POSITION_BITS = upi_pkg::POSITION_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    upi_cmd_if.sink    cmd,
    upi_pose_if.source pose,
    upi_cfg_if.sink    cfg
);

    localparam int AW = upi_pkg::MUL_A_W;
    localparam int XW = upi_pkg::XY_W;
    localparam int PW = upi_pkg::MUL_P_W;
    localparam int CW = upi_pkg::ACC_W;
    localparam logic signed [CW-1:0] POS_ROUND = CW'(64'sd1 <<< (upi_pkg::POS_SHIFT - 1));

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_TGT    = 15'b000000000000010,
        S_CHG    = 15'b000000000000100,
        S_HMUL   = 15'b000000000001000,
        S_HADD   = 15'b000000000010000,
        S_CSTART = 15'b000000000100000,
        S_CWAIT  = 15'b000000001000000,
        S_MXH    = 15'b000000010000000,
        S_MXL    = 15'b000000100000000,
        S_ACCX   = 15'b000001000000000,
        S_UPDX   = 15'b000010000000000,
        S_MYL    = 15'b000100000000000,
        S_ACCY   = 15'b001000000000000,
        S_UPDY   = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [14:0] fmax_reg, fsl_reg, tmax_reg, tsl_reg;
    logic [15:0] step_reg;

    logic [POSITION_BITS-1:0] pose_x_reg, pose_y_reg;
    logic [ANGLE_BITS-1:0]    head_reg;
    logic [14:0]              speed_reg, speed_next;
    logic signed [15:0]       turn_reg, turn_next;

    logic signed [15:0] des_f_reg, des_t_reg;
    logic [14:0]        tgt_f_reg;
    logic signed [15:0] tgt_t_reg;
    logic signed [15:0] fchg_reg, tchg_reg, fchg_next, tchg_next;

    logic signed [PW-1:0] prod_reg;
    logic [30:0]          dist_reg;
    logic signed [CW-1:0] acc_reg;

    logic signed [AW-1:0] mul_a;
    logic signed [XW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    logic out_valid_reg;
    logic signed [31:0] o_x_reg, o_y_reg;
    logic signed [15:0] o_head_reg, o_turn_reg, o_fchg_reg, o_tchg_reg;
    logic [14:0]        o_speed_reg;

    upi_pkg::cordic_ctl_t c_ctl;
    upi_pkg::cordic_sts_t c_sts;
    logic signed [XW-1:0] cos_val, sin_val;

    logic cmd_xfer, cfg_xfer, out_load;

    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cfg_xfer  = cfg.valid && cfg.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || pose.ready);
    assign c_ctl.start = (state_reg == S_CSTART);

    upi_cordic #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (c_ctl),
        .angle   (head_reg),
        .sts     (c_sts),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    // target clamps
    logic [14:0]        tgt_f_c;
    logic signed [15:0] tgt_t_c;
    logic signed [16:0] tmax_s;

    assign tmax_s = $signed({2'b00, tmax_reg});

    always_comb
    begin
        if (des_f_reg[15])
            tgt_f_c = '0;
        else if (des_f_reg[14:0] > fmax_reg)
            tgt_f_c = fmax_reg;
        else
            tgt_f_c = des_f_reg[14:0];
        if (17'(des_t_reg) > tmax_s)
            tgt_t_c = 16'(tmax_s);
        else if (17'(des_t_reg) < -tmax_s)
            tgt_t_c = 16'(-tmax_s);
        else
            tgt_t_c = des_t_reg;
    end

    // slew limit and final clamp
    logic signed [17:0] fdiff, fsl_s, fchg_w, fsum, fmax_w;
    logic signed [17:0] tdiff, tsl_s, tchg_w, tsum, tmax_w;

    always_comb
    begin
        fsl_s  = $signed({3'b000, fsl_reg});
        fmax_w = $signed({3'b000, fmax_reg});
        fdiff  = $signed({3'b000, tgt_f_reg}) - $signed({3'b000, speed_reg});
        if (fdiff > fsl_s)
            fchg_w = fsl_s;
        else if (fdiff < -fsl_s)
            fchg_w = -fsl_s;
        else
            fchg_w = fdiff;
        fsum = $signed({3'b000, speed_reg}) + fchg_w;
        if (fsum < 0)
            speed_next = '0;
        else if (fsum > fmax_w)
            speed_next = fmax_reg;
        else
            speed_next = fsum[14:0];
        fchg_next = 16'(fchg_w);

        tsl_s  = $signed({3'b000, tsl_reg});
        tmax_w = $signed({3'b000, tmax_reg});
        tdiff  = 18'(tgt_t_reg) - 18'(turn_reg);
        if (tdiff > tsl_s)
            tchg_w = tsl_s;
        else if (tdiff < -tsl_s)
            tchg_w = -tsl_s;
        else
            tchg_w = tdiff;
        tsum = 18'(turn_reg) + tchg_w;
        if (tsum > tmax_w)
            turn_next = 16'(tmax_w);
        else if (tsum < -tmax_w)
            turn_next = 16'(-tmax_w);
        else
            turn_next = 16'(tsum);
        tchg_next = 16'(tchg_w);
    end

    // shared multiplier operand select
    logic signed [XW-1:0] step_s;

    assign step_s = $signed({17'd0, step_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_HMUL:
            begin
                mul_a = AW'(turn_reg);
                mul_b = step_s;
            end
            S_CSTART:
            begin
                mul_a = $signed({2'b00, speed_reg});
                mul_b = step_s;
            end
            S_MXH:
            begin
                mul_a = $signed({2'b00, dist_reg[30:16]});
                mul_b = cos_val;
            end
            S_MXL:
            begin
                mul_a = $signed({1'b0, dist_reg[15:0]});
                mul_b = cos_val;
            end
            S_UPDX:
            begin
                mul_a = $signed({2'b00, dist_reg[30:16]});
                mul_b = sin_val;
            end
            S_MYL:
            begin
                mul_a = $signed({1'b0, dist_reg[15:0]});
                mul_b = sin_val;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (cmd_xfer) state_next = S_TGT;
            S_TGT:    state_next = S_CHG;
            S_CHG:    state_next = S_HMUL;
            S_HMUL:   state_next = S_HADD;
            S_HADD:   state_next = S_CSTART;
            S_CSTART: state_next = S_CWAIT;
            S_CWAIT:  if (c_sts.done) state_next = S_MXH;
            S_MXH:    state_next = S_MXL;
            S_MXL:    state_next = S_ACCX;
            S_ACCX:   state_next = S_UPDX;
            S_UPDX:   state_next = S_MYL;
            S_MYL:    state_next = S_ACCY;
            S_ACCY:   state_next = S_UPDY;
            S_UPDY:   state_next = S_DONE;
            S_DONE:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    logic signed [PW-1:0] hsum;

    assign hsum = prod_reg + PW'(32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fmax_reg      <= 15'd256;
            fsl_reg       <= 15'd8;
            tmax_reg      <= 15'd8192;
            tsl_reg       <= 15'd512;
            step_reg      <= 16'd655;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            head_reg      <= '0;
            speed_reg     <= '0;
            turn_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_xfer)
            begin
                unique case (cfg.index)
                    upi_pkg::REG_FORWARD_VEL_MAX:    fmax_reg <= cfg.data[14:0];
                    upi_pkg::REG_FORWARD_STEP_LIMIT: fsl_reg  <= cfg.data[14:0];
                    upi_pkg::REG_TURN_VEL_MAX:       tmax_reg <= cfg.data[14:0];
                    upi_pkg::REG_TURN_STEP_LIMIT:    tsl_reg  <= cfg.data[14:0];
                    upi_pkg::REG_STEP_TIME:          step_reg <= cfg.data[15:0];
                    upi_pkg::REG_INIT_X:
                        pose_x_reg <= POSITION_BITS'($signed(cfg.data[31:0]));
                    upi_pkg::REG_INIT_Y:
                        pose_y_reg <= POSITION_BITS'($signed(cfg.data[31:0]));
                    upi_pkg::REG_INIT_HEADING:
                        head_reg <= ANGLE_BITS'($signed(cfg.data[15:0]));
                    default: ;
                endcase
            end
            if (state_reg == S_CHG)
            begin
                speed_reg <= speed_next;
                turn_reg  <= turn_next;
            end
            if (state_reg == S_HADD)
                head_reg <= head_reg + ANGLE_BITS'(hsum >>> 16);
            if (state_reg == S_UPDX)
                pose_x_reg <= pose_x_reg + POSITION_BITS'(acc_reg >>> upi_pkg::POS_SHIFT);
            if (state_reg == S_UPDY)
                pose_y_reg <= pose_y_reg + POSITION_BITS'(acc_reg >>> upi_pkg::POS_SHIFT);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pose.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            des_f_reg <= cmd.desired_forward;
            des_t_reg <= cmd.desired_turn;
        end
        if (state_reg == S_TGT)
        begin
            tgt_f_reg <= tgt_f_c;
            tgt_t_reg <= tgt_t_c;
        end
        if (state_reg == S_CHG)
        begin
            fchg_reg <= fchg_next;
            tchg_reg <= tchg_next;
        end
        if (state_reg == S_CSTART)
            dist_reg <= mul_p[30:0];
        if ((state_reg == S_HMUL) || (state_reg == S_MXH) || (state_reg == S_MXL)
            || (state_reg == S_UPDX) || (state_reg == S_MYL))
            prod_reg <= mul_p;
        if ((state_reg == S_MXL) || (state_reg == S_MYL))
            acc_reg <= (CW'(prod_reg) <<< 16) + POS_ROUND;
        else if ((state_reg == S_ACCX) || (state_reg == S_ACCY))
            acc_reg <= acc_reg + CW'(prod_reg);
        if (out_load)
        begin
            o_x_reg     <= 32'(pose_x_reg);
            o_y_reg     <= 32'(pose_y_reg);
            o_head_reg  <= 16'(head_reg);
            o_speed_reg <= speed_reg;
            o_turn_reg  <= turn_reg;
            o_fchg_reg  <= fchg_reg;
            o_tchg_reg  <= tchg_reg;
        end
    end

    assign pose.valid          = out_valid_reg;
    assign pose.pos_x          = o_x_reg;
    assign pose.pos_y          = o_y_reg;
    assign pose.heading        = o_head_reg;
    assign pose.forward_speed  = o_speed_reg;
    assign pose.turn_rate      = o_turn_reg;
    assign pose.forward_change = o_fchg_reg;
    assign pose.turn_change    = o_tchg_reg;

    a_cordic_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        c_ctl.start |-> !c_sts.busy)
        else $error("cordic started while busy");

    a_cordic_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        c_sts.done |-> (state_reg == S_CWAIT))
        else $error("cordic result outside the wait state");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose.valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    a_cmd_starts_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> (state_reg == S_TGT))
        else $error("command transfer did not start a step");

endmodule
